/* hw/rtl/upd_pkg.sv */
// Shared types and constants for the URL percent decoder.
// Used by upd_decode, upd_emit and url_percent_decoder; depends on nothing.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // At most three result bytes come from one input byte.
  localparam int unsigned MAX_ITEMS = 3;
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_t;

  // Results of one input byte; item[0] goes out first.
  typedef struct packed {
    logic [CNT_W-1:0]         cnt;
    out_t [MAX_ITEMS-1:0]     item;
  } burst_t;

endpackage

`default_nettype wire

/* hw/rtl/upd_decode.sv */
// Escape tracking and decoding of one registered input byte into a burst of results.
// Depends on upd_pkg.
`default_nettype none

module upd_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire upd_pkg::in_t   in_i,
  input  wire logic           adv_i,
  output upd_pkg::burst_t     burst_o
);

  localparam logic [1:0] PHASE_PLAIN = 2'd0;
  localparam logic [1:0] PHASE_PCT   = 2'd1;
  localparam logic [1:0] PHASE_DIGIT = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;

  // Returns {is_hex, nibble}.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30;
      return {1'b1, t[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      t = {4'h0, c[3:0]} + 8'd9;
      return {1'b1, t[3:0]};
    end else begin
      return 5'b0_0000;
    end
  endfunction

  logic [4:0] cur_hex, held_hex;
  logic [7:0] b;
  logic       eos;

  assign b        = in_i.in_byte;
  assign eos      = in_i.end_of_string;
  assign cur_hex  = hex_decode(b);
  assign held_hex = hex_decode(held_q);

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    burst_o = '0;
    unique case (phase_q)
      PHASE_PCT: begin
        if (cur_hex[4] && !eos) begin
          held_d  = b;
          phase_d = PHASE_DIGIT;
        end else begin
          burst_o.cnt          = upd_pkg::CNT_W'(2);
          burst_o.item[0]      = '{out_byte: upd_pkg::PCT_CHAR, last: 1'b0};
          burst_o.item[1]      = '{out_byte: b, last: eos};
          phase_d              = PHASE_PLAIN;
        end
      end
      PHASE_DIGIT: begin
        if (cur_hex[4]) begin
          burst_o.cnt     = upd_pkg::CNT_W'(1);
          burst_o.item[0] = '{out_byte: {held_hex[3:0], cur_hex[3:0]}, last: eos};
        end else begin
          burst_o.cnt     = upd_pkg::CNT_W'(3);
          burst_o.item[0] = '{out_byte: upd_pkg::PCT_CHAR, last: 1'b0};
          burst_o.item[1] = '{out_byte: held_q, last: 1'b0};
          burst_o.item[2] = '{out_byte: b, last: eos};
        end
        phase_d = PHASE_PLAIN;
      end
      default: begin
        // The unused phase code behaves as plain text.
        if (b == upd_pkg::PCT_CHAR && !eos) begin
          phase_d = PHASE_PCT;
        end else begin
          burst_o.cnt     = upd_pkg::CNT_W'(1);
          burst_o.item[0] = '{out_byte: b, last: eos};
          phase_d         = PHASE_PLAIN;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PHASE_PLAIN;
      held_q  <= 8'h00;
    end else if (adv_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/upd_emit.sv */
// Result register: holds one burst of up to three bytes and hands them out in order.
// Depends on upd_pkg.
`default_nettype none

module upd_emit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire upd_pkg::burst_t burst_i,
  output logic                 can_load_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output upd_pkg::out_t        out_data_o
);

  logic [upd_pkg::CNT_W-1:0]             cnt_q, cnt_d;
  upd_pkg::out_t [upd_pkg::MAX_ITEMS-1:0] items_q, items_d;
  logic                                   pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = items_q[0];
  assign pop         = out_valid_o && out_ready_i;
  // A new burst may enter when the register is empty or when the last held byte leaves in this cycle.
  assign can_load_o  = (cnt_q == '0) || (cnt_q == upd_pkg::CNT_W'(1) && out_ready_i);

  always_comb begin
    cnt_d   = cnt_q;
    items_d = items_q;
    if (load_i) begin
      cnt_d   = burst_i.cnt;
      items_d = burst_i.item;
    end else if (pop) begin
      cnt_d = cnt_q - upd_pkg::CNT_W'(1);
      for (int i = 0; i < upd_pkg::MAX_ITEMS - 1; i++) begin
        items_d[i] = items_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    items_q <= items_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/url_percent_decoder.sv */
// Top level of the URL percent decoder: input register, decoder and result register.
// Depends on upd_pkg, upd_decode and upd_emit.
//
// Decodes a URL-encoded byte stream: '%' and two hex digits become one byte, all other
// bytes (including '+') pass unchanged, and malformed or truncated escapes are passed
// through literally. The final input byte of a string is flagged with end_of_string and
// the final output byte it causes carries last. A transfer into the input register is
// followed by decoding from that register into a three-entry result register, so the
// block takes one byte per cycle while each input byte yields at most one output byte and
// the output side is not stalled. A byte that completes a malformed escape yields two or
// three bytes and holds the input side while the result register drains; the '%' that
// opens an escape and its first digit yield nothing. A result passes through the input
// register and then the result register before it reaches the output.
`default_nettype none

module url_percent_decoder (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire upd_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output upd_pkg::out_t      out_data_o
);

  logic            in_vld_q;
  upd_pkg::in_t    in_q;
  logic            can_load;
  logic            adv;
  upd_pkg::burst_t burst;

  assign adv        = in_vld_q && can_load;
  assign in_ready_o = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  upd_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_q),
    .adv_i   (adv),
    .burst_o (burst)
  );

  upd_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // A held input byte stays put until the result register can take its burst.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(in_q)))
    else $error("input register changed while stalled");

  // A three-byte burst always opens with the percent sign, and only its third byte may close the string.
  a_three_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && burst.cnt == upd_pkg::CNT_W'(3)) |->
      (burst.item[0].out_byte == upd_pkg::PCT_CHAR && !burst.item[0].last
       && !burst.item[1].last))
    else $error("malformed three-byte burst");

  // A two-byte burst opens with the percent sign, and only its second byte may close the string.
  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && burst.cnt == upd_pkg::CNT_W'(2)) |->
      (burst.item[0].out_byte == upd_pkg::PCT_CHAR && !burst.item[0].last))
    else $error("malformed two-byte burst");

  // A loaded burst reaches the output in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && burst.cnt != '0) |=> out_valid_o)
    else $error("loaded burst not presented");

endmodule

`default_nettype wire

/* verif/url_percent_decoder_tb.sv */
// Self-checking testbench for url_percent_decoder: a directed table of escapes followed
// by random well-formed and broken escape sequences, with random idling on both sides.
// Depends on upd_pkg and the url_percent_decoder RTL; every result is checked in order.
`timescale 1ns / 1ps

module url_percent_decoder_tb;

  typedef enum logic [1:0] {PH_TEXT, PH_PERCENT, PH_DIGIT} esc_phase_e;
  typedef enum int {TOK_PLAIN, TOK_ESCAPE, TOK_BAD_FIRST, TOK_BAD_SECOND, TOK_CUT} token_e;

  typedef struct {
    upd_pkg::in_t  stim;
    bit            fixed;      // expected byte is typed in below rather than predicted
    upd_pkg::out_t fixed_res;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 23;
  localparam int unsigned N_RANDOM   = 200;

  logic          clk_i;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  upd_pkg::in_t  in_data_i   = '0;
  logic          out_ready_i = 1'b0;
  logic          in_ready_o;
  logic          out_valid_o;
  upd_pkg::out_t out_data_o;

  upd_pkg::out_t decoded_q [$];
  esc_phase_e    dec_phase = PH_TEXT;
  logic [7:0]    dec_held  = 8'h00;
  bit            send_calm = 1'b0;
  int unsigned   bytes_sent    = 0;
  int unsigned   bytes_checked = 0;
  int unsigned   mismatches    = 0;
  int unsigned   good_escapes  = 0;
  int unsigned   bad_escapes   = 0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{'{"a", 1'b0}, 1'b1, '{"a", 1'b0}},           // plain text straight after reset
    '{'{8'h00, 1'b0}, 1'b1, '{8'h00, 1'b0}},       // a zero byte is ordinary data
    '{'{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1}},       // top byte value closes a string
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"A", 1'b0}, 1'b0, '0},
    '{'{"9", 1'b0}, 1'b0, '0},
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"f", 1'b0}, 1'b0, '0},
    '{'{"0", 1'b1}, 1'b0, '0},                     // decoded byte closes a string
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"0", 1'b0}, 1'b0, '0},
    '{'{"F", 1'b0}, 1'b0, '0},
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"G", 1'b0}, 1'b0, '0},                     // bad first character
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"a", 1'b0}, 1'b0, '0},
    '{'{"z", 1'b0}, 1'b0, '0},                     // bad second character
    '{'{upd_pkg::PCT_CHAR, 1'b1}, 1'b1, '{upd_pkg::PCT_CHAR, 1'b1}}, // ends on the percent
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{"9", 1'b1}, 1'b0, '0},                     // string ends on the first digit
    '{'{upd_pkg::PCT_CHAR, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b0}, 1'b0, '0},                   // zero after percent is not hex
    '{'{"+", 1'b0}, 1'b1, '{"+", 1'b0}}            // plus signs are left alone
  };

  url_percent_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Returns the digit value, or 16 for anything that is not a hex digit.
  function automatic int unsigned hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return 16;
  endfunction

  function automatic logic [7:0] pick_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  // Half the time a character just outside the hex ranges or an extreme byte value, otherwise any non-hex byte.
  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0: c = "/";
        1: c = ":";
        2: c = "@";
        3: c = "G";
        4: c = 8'h60;
        5: c = "g";
        6: c = 8'h00;
        default: c = 8'hFF;
      endcase
    end else begin
      do c = 8'($urandom_range(0, 255)); while (hex_nibble(c) < 16);
    end
    return c;
  endfunction

  function automatic int unsigned draw_wait(bit calm);
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Advances the decoder state by one encoded byte and returns the bytes it releases.
  function automatic void decode_step(input upd_pkg::in_t item, output upd_pkg::out_t res [3],
                                      output int unsigned n);
    int unsigned v;
    v   = hex_nibble(item.in_byte);
    n   = 0;
    res = '{default: '0};
    case (dec_phase)
      PH_PERCENT: begin
        if (v < 16 && !item.end_of_string) begin
          dec_held  = item.in_byte;
          dec_phase = PH_DIGIT;
        end else begin
          res[0]    = '{upd_pkg::PCT_CHAR, 1'b0};
          res[1]    = '{item.in_byte, item.end_of_string};
          n         = 2;
          dec_phase = PH_TEXT;
          bad_escapes++;
        end
      end
      PH_DIGIT: begin
        if (v < 16) begin
          res[0] = '{8'(hex_nibble(dec_held) * 16 + v), item.end_of_string};
          n      = 1;
          good_escapes++;
        end else begin
          res[0] = '{upd_pkg::PCT_CHAR, 1'b0};
          res[1] = '{dec_held, 1'b0};
          res[2] = '{item.in_byte, item.end_of_string};
          n      = 3;
          bad_escapes++;
        end
        dec_phase = PH_TEXT;
      end
      default: begin
        if (item.in_byte == upd_pkg::PCT_CHAR && !item.end_of_string) begin
          dec_phase = PH_PERCENT;
        end else begin
          res[0]    = '{item.in_byte, item.end_of_string};
          n         = 1;
          dec_phase = PH_TEXT;
          if (item.in_byte == upd_pkg::PCT_CHAR) bad_escapes++;
        end
      end
    endcase
  endfunction

  task automatic send_byte(input upd_pkg::in_t item, input bit fixed,
                           input upd_pkg::out_t fixed_res);
    upd_pkg::out_t res [3];
    int unsigned   n;
    int unsigned   gap;
    gap = draw_wait(send_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    decode_step(item, res, n);
    if (fixed) begin
      decoded_q = {decoded_q, fixed_res};
    end else begin
      for (int k = 0; k < n; k++) decoded_q = {decoded_q, res[k]};
    end
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    upd_pkg::in_t stim_q [$];
    token_e       tok;
    bit           eos;
    int unsigned  r;

    // Random part: plain bytes, complete escapes with random content, and broken or cut-off escapes.
    while (stim_q.size() < N_RANDOM) begin
      r   = $urandom_range(0, 99);
      tok = (r < 35) ? TOK_PLAIN : (r < 75) ? TOK_ESCAPE : (r < 83) ? TOK_BAD_FIRST :
            (r < 91) ? TOK_BAD_SECOND : TOK_CUT;
      eos = ($urandom_range(0, 5) == 0);
      case (tok)
        TOK_PLAIN: stim_q = {stim_q, upd_pkg::in_t'{8'($urandom_range(0, 255)), eos}};
        TOK_ESCAPE: begin
          stim_q = {stim_q, upd_pkg::in_t'{upd_pkg::PCT_CHAR, 1'b0}};
          stim_q = {stim_q, upd_pkg::in_t'{pick_hex(), 1'b0}};
          stim_q = {stim_q, upd_pkg::in_t'{pick_hex(), eos}};
        end
        TOK_BAD_FIRST: begin
          stim_q = {stim_q, upd_pkg::in_t'{upd_pkg::PCT_CHAR, 1'b0}};
          stim_q = {stim_q, upd_pkg::in_t'{pick_non_hex(), eos}};
        end
        TOK_BAD_SECOND: begin
          stim_q = {stim_q, upd_pkg::in_t'{upd_pkg::PCT_CHAR, 1'b0}};
          stim_q = {stim_q, upd_pkg::in_t'{pick_hex(), 1'b0}};
          stim_q = {stim_q, upd_pkg::in_t'{pick_non_hex(), eos}};
        end
        default: begin
          if ($urandom_range(0, 1) == 0) begin
            stim_q = {stim_q, upd_pkg::in_t'{upd_pkg::PCT_CHAR, 1'b1}};
          end else begin
            stim_q = {stim_q, upd_pkg::in_t'{upd_pkg::PCT_CHAR, 1'b0}};
            stim_q = {stim_q, upd_pkg::in_t'{pick_hex(), 1'b1}};
          end
        end
      endcase
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].stim, directed_rows[i].fixed, directed_rows[i].fixed_res);
    end
    wait_drained();

    while (stim_q.size() != 0) begin
      if ($urandom_range(0, 19) == 0) send_calm = !send_calm;
      if ($urandom_range(0, 39) == 0) wait_drained();
      send_byte(stim_q.pop_front(), 1'b0, '0);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    $display("%0d encoded bytes sent, %0d decoded bytes checked", bytes_sent, bytes_checked);
    $display("%0d escapes decoded, %0d malformed or cut short", good_escapes, bad_escapes);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("url_percent_decoder: match");
    end else begin
      $display("url_percent_decoder: mismatch");
    end
    $finish;
  end

  // The receiving side stalls at random, with calm stretches where it never does.
  initial begin : sink
    int unsigned stall;
    bit          calm;
    calm = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 19) == 0) calm = !calm;
      stall = draw_wait(calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin : check_output
    upd_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        if (mismatches < 10) begin
          $display("byte %0d: unexpected output %02h last %0b", bytes_checked,
                   out_data_o.out_byte, out_data_o.last);
        end
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        if (want.out_byte !== out_data_o.out_byte || want.last !== out_data_o.last) begin
          if (mismatches < 10) begin
            $display("byte %0d: expected %02h last %0b, got %02h last %0b", bytes_checked,
                     want.out_byte, want.last, out_data_o.out_byte, out_data_o.last);
          end
          mismatches++;
        end
      end
      bytes_checked++;
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("url_percent_decoder: mismatch");
    $finish;
  end

endmodule
